FILE: design/morse_keyer_segment_sequencer_top_assert.svh
// Assertion macros shared by the Morse keyer segment sequencer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef MORSE_KEYER_SEGMENT_SEQUENCER_TOP_ASSERT_SVH
`define MORSE_KEYER_SEGMENT_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset disables the check.
`define MKS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mks assertion failed");
// Next-cycle implication, reset disables the check.
`define MKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mks assertion failed");
`else
`define MKS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/mks_pkg.sv
// Package for the Morse keyer segment sequencer: code table, unit multiples,
// configuration struct and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mks_pkg;

    localparam logic [7:0]  CODE_DEFAULT    = 8'hC0;
    localparam logic [7:0]  CODE_SPACE      = 8'h01;
    localparam logic [7:0]  CH_TILDE        = 8'd126;
    localparam logic [7:0]  CH_BACKQUOTE    = 8'd96;
    localparam logic [15:0] UNIT_TICKS_RST  = 16'd120;
    localparam logic [23:0] LEAD_IN_RST     = 24'd1000;

    // Register indexes on the configuration channel
    localparam logic [1:0]  REG_UNIT_TICKS  = 2'd0;
    localparam logic [1:0]  REG_LEAD_IN     = 2'd1;

    // Multiple of one unit requested from the scaling unit
    typedef enum logic [1:0] {
        UNITS_1 = 2'd0,
        UNITS_3 = 2'd1,
        UNITS_7 = 2'd2
    } mks_units_t;

    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [23:0] lead_in_ticks;
    } mks_cfg_t;

    // Code bytes for ASCII 32..95; marker bit above the elements, LSB first
    localparam logic [7:0] CODE_TABLE [64] = '{
        8'h01, 8'h75, 8'h52, 8'hC0, 8'hC8, 8'hC0, 8'h22, 8'h5E,
        8'h2D, 8'h6D, 8'hC0, 8'h2A, 8'h73, 8'h61, 8'h6A, 8'h29,
        8'h3F, 8'h3E, 8'h3C, 8'h38, 8'h30, 8'h20, 8'h21, 8'h23,
        8'h27, 8'h2F, 8'h47, 8'h55, 8'hC0, 8'h31, 8'hC0, 8'h4C,
        8'h56, 8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B,
        8'h10, 8'h04, 8'h1E, 8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F,
        8'h16, 8'h1B, 8'h0A, 8'h08, 8'h03, 8'h0C, 8'h18, 8'h0E,
        8'h19, 8'h1D, 8'h13, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'h6C
    };

    // Fold lower case, then look up; anything outside 32..95 gets the default
    function automatic logic [7:0] mks_code_lookup(input logic [7:0] ch);
        logic [7:0] uc;
        logic [7:0] ofs;
        uc = ch;
        if (ch >= 8'd97 && ch <= 8'd122)
        begin
            uc = ch - 8'd32;
        end
        ofs = uc - 8'd32;
        if (uc < 8'd32 || uc > 8'd95)
        begin
            return CODE_DEFAULT;
        end
        return CODE_TABLE[ofs[5:0]];
    endfunction

endpackage

`default_nettype wire

FILE: design/mks_scale.sv
// Shared scaling unit: one add/subtract forms 1, 3 or 7 times unit_ticks.
// Depends on mks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mks_scale
    import mks_pkg::*;
(
    input  wire logic [15:0] unit_ticks,
    input  wire mks_units_t  units,
    output logic [23:0]      ticks
);

    logic [18:0] base;
    logic [18:0] u_ext;
    logic [18:0] sum;

    // 3u = 2u + u, 7u = 8u - u, 1u = 0 + u
    assign u_ext = {3'b000, unit_ticks};

    always_comb
    begin
        unique case (units)
            UNITS_3: base = {2'b00, unit_ticks, 1'b0};
            UNITS_7: base = {unit_ticks, 3'b000};
            default: base = '0;
        endcase
        sum = (units == UNITS_7) ? (base - u_ext) : (base + u_ext);
    end

    assign ticks = {5'b00000, sum};

endmodule

`default_nettype wire

FILE: design/mks_seq.sv
// Segment sequencer: walks the code byte one element per step and holds the
// output register. Depends on mks_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "morse_keyer_segment_sequencer_top_assert.svh"

module mks_seq
    import mks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mks_cfg_t    cfg,
    // input item
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_char,
    input  wire logic        in_start,
    // shared scaling unit
    output mks_units_t       scale_units,
    input  wire logic [23:0] scale_ticks,
    // segment out
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             out_key_on,
    output logic [23:0]      out_ticks,
    output logic             out_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_ON,
        ST_OFF,
        ST_SP1,
        ST_SP2
    } state_t;

    state_t      state_reg, state_next;
    logic        digraph_reg, digraph_next;
    logic [7:0]  code_shift_reg, code_shift_next;
    logic [2:0]  element_index_reg, element_index_next;
    logic        skip_reg, skip_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_key_on_reg, out_key_on_next;
    logic [23:0] out_ticks_reg, out_ticks_next;
    logic        out_last_reg, out_last_next;

    logic        slot_free;
    logic        more;
    logic        is_skip;
    logic        dg;
    logic [7:0]  code;

    assign slot_free = !out_valid_reg || out_ready;
    assign more      = (code_shift_reg[7:2] != 6'd0);
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        digraph_next       = digraph_reg;
        code_shift_next    = code_shift_reg;
        element_index_next = element_index_reg;
        skip_next          = skip_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_key_on_next    = out_key_on_reg;
        out_ticks_next     = out_ticks_reg;
        out_last_next      = out_last_reg;
        scale_units        = UNITS_1;
        is_skip            = (in_char == CH_TILDE) || (in_char == CH_BACKQUOTE);
        code               = mks_code_lookup(in_char);
        dg                 = in_start ? 1'b0 : digraph_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // accept one character and decode it
                if (in_valid)
                begin
                    if (in_char == CH_BACKQUOTE)
                    begin
                        dg = ~dg;
                    end
                    digraph_next       = dg;
                    skip_next          = is_skip;
                    code_shift_next    = is_skip ? 8'd0 : code;
                    element_index_next = 3'd0;
                    if (in_start)
                    begin
                        state_next = ST_LEAD;
                    end
                    else if (is_skip)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (code == CODE_SPACE)
                    begin
                        state_next = ST_SP1;
                    end
                    else
                    begin
                        state_next = ST_ON;
                    end
                end
            end
            ST_LEAD:
            begin
                // lead-in silence; last if the character sends nothing else
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_on_next = 1'b0;
                    out_ticks_next  = cfg.lead_in_ticks;
                    out_last_next   = skip_reg;
                    if (skip_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (code_shift_reg == CODE_SPACE)
                    begin
                        state_next = ST_SP1;
                    end
                    else
                    begin
                        state_next = ST_ON;
                    end
                end
            end
            ST_ON:
            begin
                // dit or dah
                scale_units = code_shift_reg[0] ? UNITS_3 : UNITS_1;
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_on_next = 1'b1;
                    out_ticks_next  = scale_ticks;
                    out_last_next   = 1'b0;
                    state_next      = ST_OFF;
                end
            end
            ST_OFF:
            begin
                // gap after the element; character gap after the last one, unless in digraph mode
                scale_units = (more || digraph_reg) ? UNITS_1 : UNITS_3;
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_on_next = 1'b0;
                    out_ticks_next  = scale_ticks;
                    out_last_next   = !more;
                    if (more)
                    begin
                        code_shift_next    = {1'b0, code_shift_reg[7:1]};
                        element_index_next = element_index_reg + 3'd1;
                        state_next         = ST_ON;
                    end
                    else
                    begin
                        code_shift_next    = 8'd0;
                        element_index_next = 3'd0;
                        state_next         = ST_IDLE;
                    end
                end
            end
            ST_SP1:
            begin
                // word space
                scale_units = UNITS_7;
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_on_next = 1'b0;
                    out_ticks_next  = scale_ticks;
                    out_last_next   = 1'b0;
                    state_next      = ST_SP2;
                end
            end
            ST_SP2:
            begin
                scale_units = digraph_reg ? UNITS_1 : UNITS_3;
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_on_next = 1'b0;
                    out_ticks_next  = scale_ticks;
                    out_last_next   = 1'b1;
                    code_shift_next = 8'd0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            digraph_reg       <= 1'b0;
            code_shift_reg    <= 8'd0;
            element_index_reg <= 3'd0;
            skip_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            digraph_reg       <= digraph_next;
            code_shift_reg    <= code_shift_next;
            element_index_reg <= element_index_next;
            skip_reg          <= skip_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_key_on_reg <= out_key_on_next;
        out_ticks_reg  <= out_ticks_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_key_on = out_key_on_reg;
    assign out_ticks  = out_ticks_reg;
    assign out_last   = out_last_reg;

    // A character that sends something keeps the sequencer busy
    `MKS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        in_valid && in_ready && (in_start || !is_skip), state_reg != ST_IDLE)
    // An element is only keyed while a marker lies above it
    `MKS_ASSERT_IMPL(a_element_present, clk, rst_n,
        state_reg == ST_ON, code_shift_reg[7:1] != 7'd0 && element_index_reg != 3'd7)
    // Closing segment returns the sequencer to idle
    `MKS_ASSERT_NEXT(a_last_ends_item, clk, rst_n,
        out_valid_next && out_last_next && slot_free && state_reg != ST_IDLE,
        state_reg == ST_IDLE)
    // Key-on segments never close a character
    `MKS_ASSERT_IMPL(a_on_not_last, clk, rst_n,
        out_valid_reg && out_key_on_reg, !out_last_reg)

endmodule

`default_nettype wire

FILE: design/morse_keyer_segment_sequencer_top.sv
// Channel     Dir  Fields (lowest bit up)
// s_*         in   tdata: character[7:0]; tuser: message_start
// m_*         out  tdata: key_on, duration_ticks[24:1], pad; tlast: last_segment
// cfg_*       in   index 0 unit_ticks, 1 lead_in_ticks; data low bits
//
// A character sends up to 15 segments (lead-in plus seven element pairs), or none;
// s_tready is low while segments are being emitted. The sequencer steps one
// element at a time through the shared scaling adder and the single output
// register. m_tready low stalls the sequencer in place.
// Reset (rst_n, async) clears digraph mode and restores the register defaults.
// Top level: configuration registers, shared scaling unit and sequencer.
// Depends on mks_pkg, mks_scale and mks_seq.
`timescale 1ns / 1ps
`default_nettype none

module morse_keyer_segment_sequencer_top
    import mks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic        s_tuser,   // [0] message_start
    // segment stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [0] key_on, [24:1] duration_ticks, zero pad
    output logic             m_tlast,   // last_segment
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    mks_cfg_t    cfg_reg, cfg_next;
    mks_units_t  scale_units;
    logic [23:0] scale_ticks;
    logic        out_key_on;
    logic [23:0] out_ticks;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_UNIT_TICKS)
            begin
                cfg_next.unit_ticks = cfg_data[15:0];
            end
            else if (cfg_index == REG_LEAD_IN)
            begin
                cfg_next.lead_in_ticks = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ticks    <= UNIT_TICKS_RST;
            cfg_reg.lead_in_ticks <= LEAD_IN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mks_scale u_scale (
        .unit_ticks (cfg_reg.unit_ticks),
        .units      (scale_units),
        .ticks      (scale_ticks)
    );

    mks_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_char     (s_tdata),
        .in_start    (s_tuser),
        .scale_units (scale_units),
        .scale_ticks (scale_ticks),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_key_on  (out_key_on),
        .out_ticks   (out_ticks),
        .out_last    (m_tlast)
    );

    assign m_tdata = {7'd0, out_ticks, out_key_on};

endmodule

`default_nettype wire
